// ===== rtl/cke_pkg.sv =====
// Shared constants, register codes and the exp(-2^e) factor function of the kernel evaluator.
package cke_pkg;

  localparam int ARG_INT_BITS = 5;
  localparam int COORD_BITS = 32;
  localparam int LEN_BITS = 32;
  localparam int CORR_BITS = 17;
  localparam int OUT_FRAC_BITS = 16;
  localparam logic [CORR_BITS-1:0] CORR_ONE = 17'd65536;

  localparam logic [2:0] KT_SEP_GAUSS = 3'd1;
  localparam logic [2:0] KT_ISO_GAUSS = 3'd2;
  localparam logic [2:0] KT_SEP_EXP = 3'd3;
  localparam logic [2:0] KT_ISO_EXP = 3'd4;

  localparam logic [1:0] CFG_KERNEL_TYPE = 2'd0;
  localparam logic [1:0] CFG_LENGTH_X = 2'd1;
  localparam logic [1:0] CFG_LENGTH_Y = 2'd2;

  // Returns exp(-2^e) in Q0.32. Only evaluated at elaboration.
  function automatic logic [31:0] exp_neg_pow2(input int e);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    int s;
    s = (e < 0) ? -e : 1;
    term = 64'd1 << 62;
    sum = term;
    for (int k = 1; k <= 12; k++) begin
      term = (term >> s) / 64'(k);
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + (64'd1 << 29)) >> 30;
    if (e >= 0) begin
      for (int i = 0; i <= e; i++) begin
        v = (v * v + (64'd1 << 31)) >> 32;
      end
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/cke_div_pipe.sv =====
// Pipelined restoring divider that forms one saturated axis ratio per cycle while en is high.
module cke_div_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                           clk,
  input  logic                                           en,
  input  logic [cke_pkg::COORD_BITS-1:0]                 axis_dist,
  input  logic [cke_pkg::LEN_BITS-1:0]                   divisor,
  output logic [FRAC_BITS+cke_pkg::ARG_INT_BITS:0]       ratio
);

  localparam int QW = FRAC_BITS + cke_pkg::ARG_INT_BITS + 1;
  localparam int LW = cke_pkg::LEN_BITS;
  localparam logic [QW-1:0] ARG_MAX = {1'b1, {(QW-1){1'b0}}};

  logic [LW-1:0] rem_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [5:0]    dlo_r [QW];
  logic          ovf_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int B = QW - 1 - j;
    logic [LW-1:0] rem_i;
    logic [QW-1:0] quo_i;
    logic [5:0]    dlo_i;
    logic          ovf_i;
    logic          bit_i;
    logic [LW:0]   trial;
    logic [LW-1:0] rem_n;
    logic [QW-1:0] quo_n;

    if (j == 0) begin : g_first
      assign rem_i = {6'd0, axis_dist[LW-1:6]};
      assign quo_i = '0;
      assign dlo_i = axis_dist[5:0];
      assign ovf_i = ({6'd0, axis_dist[LW-1:6]} >= divisor);
    end else begin : g_next
      assign rem_i = rem_r[j-1];
      assign quo_i = quo_r[j-1];
      assign dlo_i = dlo_r[j-1];
      assign ovf_i = ovf_r[j-1];
    end

    if (B >= FRAC_BITS) begin : g_bit
      assign bit_i = dlo_i[B-FRAC_BITS];
    end else begin : g_zero
      assign bit_i = 1'b0;
    end

    assign trial = {rem_i, bit_i};

    always_comb begin
      quo_n = quo_i;
      if (trial >= {1'b0, divisor}) begin
        rem_n = LW'(trial - {1'b0, divisor});
        quo_n[B] = 1'b1;
      end else begin
        rem_n = trial[LW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_n;
        quo_r[j] <= quo_n;
        dlo_r[j] <= dlo_i;
        ovf_r[j] <= ovf_i;
      end
    end
  end

  assign ratio = (ovf_r[QW-1] || (quo_r[QW-1] > ARG_MAX)) ? ARG_MAX : quo_r[QW-1];

endmodule

// ===== rtl/cke_exp_pipe.sv =====
// Pipelined exp(-t) as a product of one constant factor per argument bit; the top bit forces zero.
module cke_exp_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic [FRAC_BITS+cke_pkg::ARG_INT_BITS:0] arg,
  input  logic                                     kill,
  output logic [32:0]                              acc,
  output logic                                     zero
);

  localparam int QW = FRAC_BITS + cke_pkg::ARG_INT_BITS + 1;
  localparam int EW = FRAC_BITS + cke_pkg::ARG_INT_BITS;

  logic [32:0]   acc_r [EW];
  logic [QW-1:0] arg_r [EW];
  logic          zero_r [EW];

  for (genvar j = 0; j < EW; j++) begin : g_stage
    localparam logic [31:0] FAC = cke_pkg::exp_neg_pow2(j - FRAC_BITS);
    logic [32:0]   acc_i;
    logic [QW-1:0] arg_i;
    logic          zero_i;
    logic [64:0]   prod;
    logic [32:0]   acc_n;

    if (j == 0) begin : g_first
      assign acc_i = {1'b1, 32'd0};
      assign arg_i = arg;
      assign zero_i = kill | arg[QW-1];
    end else begin : g_next
      assign acc_i = acc_r[j-1];
      assign arg_i = arg_r[j-1];
      assign zero_i = zero_r[j-1];
    end

    assign prod = 65'(acc_i) * 65'(FAC);
    assign acc_n = 33'((prod + 65'h0_8000_0000) >> 32);

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[j] <= arg_i[j] ? acc_n : acc_i;
        arg_r[j] <= arg_i;
        zero_r[j] <= zero_i;
      end
    end
  end

  assign acc = acc_r[EW-1];
  assign zero = zero_r[EW-1];

endmodule

// ===== rtl/covariance_kernel_eval_core.sv =====
// Top level of the covariance kernel evaluator: distances, ratios, argument, square root, exp.
// The core accepts one point pair per clock cycle while in_ready is high and returns its
// correlation. It is built of the ratio divider and the square root, one stage per quotient
// or root bit each, the exp product chain, one stage per argument bit below the top one, and
// four single stages for distance, squaring, argument and output. All stages but the output
// register move together; the core keeps accepting while a result waits at the output until
// the last stage is occupied. Configuration must only be written while the core is empty.
module covariance_kernel_eval_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_first_x,
  input  logic signed [31:0]  in_first_y,
  input  logic signed [31:0]  in_first_z,
  input  logic signed [31:0]  in_second_x,
  input  logic signed [31:0]  in_second_y,
  input  logic signed [31:0]  in_second_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [16:0]         out_correlation,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  localparam int QW = FRAC_BITS + cke_pkg::ARG_INT_BITS + 1;
  localparam int EW = FRAC_BITS + cke_pkg::ARG_INT_BITS;
  localparam int NS = 2 * QW + 3 + EW;
  localparam int SW = 2 * QW - FRAC_BITS + 2;
  localparam logic [QW-1:0] ARG_MAX = {1'b1, {(QW-1){1'b0}}};
  localparam logic [2*QW:0] HALF = (2*QW+1)'(1) << (FRAC_BITS - 1);

  logic [2:0]  kernel_type_r;
  logic [31:0] length_x_r;
  logic [31:0] length_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_type_r <= cke_pkg::KT_SEP_GAUSS;
      length_x_r <= 32'd65536;
      length_y_r <= 32'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cke_pkg::CFG_KERNEL_TYPE: kernel_type_r <= cfg_wdata[2:0];
        cke_pkg::CFG_LENGTH_X:    length_x_r <= cfg_wdata;
        cke_pkg::CFG_LENGTH_Y:    length_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [31:0] len_x_eff;
  logic [31:0] len_y_eff;
  logic        sep_kernel;

  assign len_x_eff = (length_x_r == '0) ? 32'd1 : length_x_r;
  assign len_y_eff = (length_y_r == '0) ? 32'd1 : length_y_r;
  assign sep_kernel = (kernel_type_r == cke_pkg::KT_SEP_GAUSS) ||
                      (kernel_type_r == cke_pkg::KT_SEP_EXP);

  // Pipeline control: every stage before the output register advances together.
  logic [NS-1:0] vld_r;
  logic          out_valid_r;
  logic          pipe_en;

  assign pipe_en = !vld_r[NS-1] || !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // Distance stage.
  logic [32:0] diff_x;
  logic [32:0] diff_y;
  logic [32:0] diff_z;
  logic [31:0] dx_r;
  logic [31:0] dy_r;
  logic [31:0] dz_r;

  assign diff_x = {in_first_x[31], in_first_x} - {in_second_x[31], in_second_x};
  assign diff_y = {in_first_y[31], in_first_y} - {in_second_y[31], in_second_y};
  assign diff_z = {in_first_z[31], in_first_z} - {in_second_z[31], in_second_z};

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dx_r <= diff_x[32] ? 32'(-diff_x) : diff_x[31:0];
      dy_r <= diff_y[32] ? 32'(-diff_y) : diff_y[31:0];
      dz_r <= diff_z[32] ? 32'(-diff_z) : diff_z[31:0];
    end
  end

  // Ratio dividers.
  logic [QW-1:0] ratio_x;
  logic [QW-1:0] ratio_y;
  logic [QW-1:0] ratio_z;

  cke_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .en(pipe_en), .axis_dist(dx_r), .divisor(len_x_eff), .ratio(ratio_x)
  );
  cke_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .en(pipe_en), .axis_dist(dy_r), .divisor(sep_kernel ? len_y_eff : len_x_eff),
    .ratio(ratio_y)
  );
  cke_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk(clk), .en(pipe_en), .axis_dist(dz_r), .divisor(len_x_eff), .ratio(ratio_z)
  );

  // Squaring stage.
  logic [QW-1:0]   rx_r;
  logic [QW-1:0]   ry_r;
  logic [2*QW-1:0] sqx_r;
  logic [2*QW-1:0] sqy_r;
  logic [2*QW-1:0] sqz_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rx_r <= ratio_x;
      ry_r <= ratio_y;
      sqx_r <= (2*QW)'(ratio_x) * (2*QW)'(ratio_x);
      sqy_r <= (2*QW)'(ratio_y) * (2*QW)'(ratio_y);
      sqz_r <= (2*QW)'(ratio_z) * (2*QW)'(ratio_z);
    end
  end

  // Argument stage.
  logic [SW-1:0]   rsx;
  logic [SW-1:0]   rsy;
  logic [SW-1:0]   rsz;
  logic [SW-1:0]   sum2;
  logic [SW-1:0]   sum3;
  logic [QW:0]     lin;
  logic [QW-1:0]   t_nxt;
  logic            iso_nxt;
  logic            kill_nxt;
  logic [QW-1:0]   tc_r;
  logic [2*QW-1:0] vs_r;
  logic            iso_r;
  logic            kill_r;

  assign rsx = SW'(({1'b0, sqx_r} + HALF) >> FRAC_BITS);
  assign rsy = SW'(({1'b0, sqy_r} + HALF) >> FRAC_BITS);
  assign rsz = SW'(({1'b0, sqz_r} + HALF) >> FRAC_BITS);
  assign sum2 = rsx + rsy;
  assign sum3 = rsx + rsy + rsz;
  assign lin = (QW+1)'(rx_r) + (QW+1)'(ry_r);

  always_comb begin
    t_nxt = '0;
    iso_nxt = 1'b0;
    kill_nxt = 1'b0;
    case (kernel_type_r)
      cke_pkg::KT_SEP_GAUSS: t_nxt = (sum2 > SW'(ARG_MAX)) ? ARG_MAX : QW'(sum2);
      cke_pkg::KT_ISO_GAUSS: t_nxt = (sum3 > SW'(ARG_MAX)) ? ARG_MAX : QW'(sum3);
      cke_pkg::KT_SEP_EXP:   t_nxt = (lin > (QW+1)'(ARG_MAX)) ? ARG_MAX : QW'(lin);
      cke_pkg::KT_ISO_EXP:   iso_nxt = 1'b1;
      default:               kill_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      tc_r <= t_nxt;
      vs_r <= sqx_r + sqy_r + sqz_r;
      iso_r <= iso_nxt;
      kill_r <= kill_nxt;
    end
  end

  // Square root stages, one root bit each.
  logic [QW+1:0]   sr_rem_r [QW];
  logic [QW-1:0]   sr_root_r [QW];
  logic [2*QW-1:0] sr_v_r [QW];
  logic [QW-1:0]   sr_t_r [QW];
  logic            sr_iso_r [QW];
  logic            sr_kill_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_sqrt
    localparam int P = QW - 1 - j;
    logic [QW+1:0]   rem_i;
    logic [QW-1:0]   root_i;
    logic [2*QW-1:0] v_i;
    logic [QW-1:0]   t_i;
    logic            iso_i;
    logic            kill_i;
    logic [QW+3:0]   rem4;
    logic [QW+3:0]   trial;

    if (j == 0) begin : g_first
      assign rem_i = '0;
      assign root_i = '0;
      assign v_i = vs_r;
      assign t_i = tc_r;
      assign iso_i = iso_r;
      assign kill_i = kill_r;
    end else begin : g_next
      assign rem_i = sr_rem_r[j-1];
      assign root_i = sr_root_r[j-1];
      assign v_i = sr_v_r[j-1];
      assign t_i = sr_t_r[j-1];
      assign iso_i = sr_iso_r[j-1];
      assign kill_i = sr_kill_r[j-1];
    end

    assign rem4 = {rem_i, v_i[2*P+1:2*P]};
    assign trial = (QW+4)'({root_i, 2'b01});

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        if (rem4 >= trial) begin
          sr_rem_r[j] <= (QW+2)'(rem4 - trial);
          sr_root_r[j] <= {root_i[QW-2:0], 1'b1};
        end else begin
          sr_rem_r[j] <= rem4[QW+1:0];
          sr_root_r[j] <= {root_i[QW-2:0], 1'b0};
        end
        sr_v_r[j] <= v_i;
        sr_t_r[j] <= t_i;
        sr_iso_r[j] <= iso_i;
        sr_kill_r[j] <= kill_i;
      end
    end
  end

  logic [QW-1:0] root_sat;
  logic [QW-1:0] exp_arg;

  assign root_sat = (sr_root_r[QW-1] > ARG_MAX) ? ARG_MAX : sr_root_r[QW-1];
  assign exp_arg = sr_iso_r[QW-1] ? root_sat : sr_t_r[QW-1];

  // Exponential stages.
  logic [32:0] exp_acc;
  logic        exp_zero;

  cke_exp_pipe #(.FRAC_BITS(FRAC_BITS)) u_exp (
    .clk(clk), .en(pipe_en), .arg(exp_arg), .kill(sr_kill_r[QW-1]),
    .acc(exp_acc), .zero(exp_zero)
  );

  // Output register.
  logic [17:0] corr_rnd;
  logic [16:0] corr_nxt;
  logic [16:0] out_corr_r;

  assign corr_rnd = 18'((34'(exp_acc) + 34'd32768) >> cke_pkg::OUT_FRAC_BITS);

  always_comb begin
    if (exp_zero) begin
      corr_nxt = '0;
    end else if (corr_rnd > 18'(cke_pkg::CORR_ONE)) begin
      corr_nxt = cke_pkg::CORR_ONE;
    end else begin
      corr_nxt = corr_rnd[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_corr_r <= corr_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_correlation = out_corr_r;

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r))
    else $error("pipeline valid bits moved while stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted transfer did not enter the pipeline");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while the pipeline is blocked");

  a_corr_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_correlation <= cke_pkg::CORR_ONE)
    else $error("correlation above one");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for covariance_kernel_eval_core with a queue-fed driver, a monitor and a predictor.
`timescale 1ns / 100ps

module tb;

  localparam logic [2:0] KT_NONE_LO = 3'd0;
  localparam logic [2:0] KT_NONE_MID = 3'd5;
  localparam logic [2:0] KT_NONE_HI = 3'd7;
  localparam int FRACB = 16;
  localparam int EXP_BITS = FRACB + cke_pkg::ARG_INT_BITS;
  localparam logic [63:0] ARG_LIMIT = 64'd1 << EXP_BITS;

  typedef struct packed {
    logic signed [31:0] ax, ay, az, bx, by, bz;
  } pair_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  pair_t cur;
  logic [16:0] out_correlation;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [31:0] cfg_wdata;

  pair_t pending_pairs[$];
  logic [16:0] expected_corr[$];
  logic [63:0] factor_q32[0:EXP_BITS-1];
  logic [2:0] kind;
  logic [31:0] len_x, len_y;
  bit took, calm, hold_in;
  int errors;

  covariance_kernel_eval_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_x(cur.ax), .in_first_y(cur.ay), .in_first_z(cur.az),
    .in_second_x(cur.bx), .in_second_y(cur.by), .in_second_z(cur.bz),
    .out_valid(out_valid), .out_ready(out_ready), .out_correlation(out_correlation),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  function automatic logic [63:0] exp_factor(int e);
    logic [63:0] sum, term, v;
    if (e < 0) begin
      term = 64'd1 << 62;
      sum = term;
      for (int k = 1; k <= 12; k++) begin
        term = (term >> (-e)) / 64'(k);
        sum = (k % 2 == 1) ? sum - term : sum + term;
      end
      return (sum + (64'd1 << 29)) >> 30;
    end
    v = exp_factor(-1);
    for (int i = 0; i <= e; i++) v = (v * v + (64'd1 << 31)) >> 32;
    return v;
  endfunction

  function automatic logic [63:0] span(logic signed [31:0] a, logic signed [31:0] b);
    longint p, q;
    p = a;
    q = b;
    return (p > q) ? 64'(p - q) : 64'(q - p);
  endfunction

  function automatic logic [63:0] ratio(logic [63:0] d, logic [31:0] len);
    logic [63:0] l, r;
    l = (len == 0) ? 64'd1 : 64'(len);
    r = (d << FRACB) / l;
    return (r > ARG_LIMIT) ? ARG_LIMIT : r;
  endfunction

  function automatic logic [63:0] square_q(logic [63:0] r);
    return (r * r + (64'd1 << (FRACB - 1))) >> FRACB;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [16:0] decay(logic [63:0] t);
    logic [63:0] acc;
    if (t > ARG_LIMIT) t = ARG_LIMIT;
    if (t >= ARG_LIMIT) return 17'd0;
    acc = 64'd1 << 32;
    for (int k = 0; k < EXP_BITS; k++)
      if (t[k]) acc = (acc * factor_q32[k] + (64'd1 << 31)) >> 32;
    acc = (acc + (64'd1 << 15)) >> 16;
    return (acc > 64'(cke_pkg::CORR_ONE)) ? cke_pkg::CORR_ONE : acc[16:0];
  endfunction

  function automatic logic [16:0] correlation_of(pair_t p);
    logic [63:0] dx, dy, dz, rx, ry, rz;
    dx = span(p.ax, p.bx);
    dy = span(p.ay, p.by);
    dz = span(p.az, p.bz);
    case (kind)
      cke_pkg::KT_SEP_GAUSS: begin
        return decay(square_q(ratio(dx, len_x)) + square_q(ratio(dy, len_y)));
      end
      cke_pkg::KT_ISO_GAUSS: begin
        return decay(square_q(ratio(dx, len_x)) + square_q(ratio(dy, len_x))
                     + square_q(ratio(dz, len_x)));
      end
      cke_pkg::KT_SEP_EXP: begin
        return decay(ratio(dx, len_x) + ratio(dy, len_y));
      end
      cke_pkg::KT_ISO_EXP: begin
        rx = ratio(dx, len_x);
        ry = ratio(dy, len_x);
        rz = ratio(dz, len_x);
        return decay(root_floor(rx * rx + ry * ry + rz * rz));
      end
      default: return 17'd0;
    endcase
  endfunction

  task automatic report(string msg);
    errors++;
    $display("ERROR %0t: %s", $realtime, msg);
  endtask

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    took = 0;
    if (rst_n && in_valid && in_ready) begin
      expected_corr.push_back(correlation_of(cur));
      took = 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_corr.size() == 0) begin
        report($sformatf("unexpected correlation %0d", out_correlation));
      end else begin
        if (out_correlation !== expected_corr[0])
          report($sformatf("correlation %0d, predicted %0d", out_correlation,
                           expected_corr[0]));
        void'(expected_corr.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    logic nv;
    nv = in_valid;
    if (rst_n) begin
      if (!in_valid || took) begin
        nv = 0;
        if (!hold_in && pending_pairs.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
          cur <= pending_pairs.pop_front();
          nv = 1;
        end
      end
      out_ready <= calm || $urandom_range(99) >= 33;
    end
    in_valid <= nv;
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      cke_pkg::CFG_KERNEL_TYPE: kind = val[2:0];
      cke_pkg::CFG_LENGTH_X: len_x = val;
      default: len_y = val;
    endcase
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic drain();
    while (pending_pairs.size() != 0 || in_valid || expected_corr.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] near(logic [31:0] base, logic [31:0] len);
    logic [63:0] reach;
    reach = (len == 0) ? 64'd4 : 64'(len) * 3;
    if (reach > 64'hFFFF_FFFF) reach = 64'hFFFF_FFFF;
    case ($urandom_range(9))
      0: return $urandom;
      1: return base;
      2: return base - 32'($urandom_range(0, 32'(reach)));
      default: return base + 32'($urandom_range(0, 32'(reach)));
    endcase
  endfunction

  task automatic random_pairs(int n);
    pair_t p;
    for (int i = 0; i < n; i++) begin
      p.ax = $urandom;
      p.ay = $urandom;
      p.az = $urandom;
      p.bx = near(p.ax, len_x);
      p.by = near(p.ay, (kind == cke_pkg::KT_SEP_GAUSS || kind == cke_pkg::KT_SEP_EXP)
                        ? len_y : len_x);
      p.bz = near(p.az, len_x);
      pending_pairs.push_back(p);
    end
  endtask

  initial begin
    logic [2:0] kinds[13];
    logic [31:0] lxs[13], lys[13];
    pair_t p;
    kinds = '{cke_pkg::KT_SEP_GAUSS, cke_pkg::KT_ISO_GAUSS, cke_pkg::KT_SEP_EXP,
              cke_pkg::KT_ISO_EXP, cke_pkg::KT_SEP_GAUSS, cke_pkg::KT_ISO_EXP,
              cke_pkg::KT_SEP_EXP, cke_pkg::KT_ISO_GAUSS, KT_NONE_LO, KT_NONE_MID,
              KT_NONE_HI, cke_pkg::KT_SEP_EXP, cke_pkg::KT_SEP_GAUSS};
    lxs = '{32'h0001_0000, 32'h0003_8000, 32'h0000_4000, 32'h0010_0000, 32'd0, 32'd1,
            32'hFFFF_FFFF, 32'h0100_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
            32'd1, 32'h0002_0000};
    lys = '{32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_FFFF,
            32'd1, 32'd0, 32'h0000_8000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
            32'hFFFF_FFFF, 32'h0000_0100};
    for (int i = 0; i < EXP_BITS; i++) factor_q32[i] = exp_factor(i - FRACB);
    errors = 0;
    kind = cke_pkg::KT_SEP_GAUSS;
    len_x = 32'h0001_0000;
    len_y = 32'h0001_0000;
    rst_n = 0;
    in_valid = 0;
    out_ready = 0;
    cur = '0;
    cfg_wr_en = 0;
    cfg_index = cke_pkg::CFG_KERNEL_TYPE;
    cfg_wdata = 0;
    calm = 0;
    hold_in = 0;
    took = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    pending_pairs.push_back('0);
    pending_pairs.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_pairs.push_back('{32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0});
    for (int i = 0; i < 6; i++) begin
      p = '0;
      p.bx = 32'h0000_8000 << i;
      p.by = -(32'h0000_4000 << i);
      p.bz = 32'd1 << (3 * i);
      pending_pairs.push_back(p);
    end
    pending_pairs.push_back('{32'd5, 32'd7, 32'd9, 32'd5, 32'd7, 32'd9});
    pending_pairs.push_back('{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'h0, 32'h8000_0000});
    random_pairs(120);
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      cfg_write(cke_pkg::CFG_KERNEL_TYPE, 32'(kinds[ph]));
      cfg_write(cke_pkg::CFG_LENGTH_X, lxs[ph]);
      cfg_write(cke_pkg::CFG_LENGTH_Y, lys[ph]);
      calm = (ph == 4);
      pending_pairs.push_back('0);
      pending_pairs.push_back('{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0});
      random_pairs(60);
      if (ph == 6) begin
        while (pending_pairs.size() != 0) @(posedge clk);
        hold_in = 1;
        while (in_valid || expected_corr.size() != 0) @(posedge clk);
        hold_in = 0;
      end
      random_pairs(60);
      drain();
    end

    if (errors == 0) begin
      $display("covariance_kernel_eval_core verification clean");
    end else begin
      $display("covariance_kernel_eval_core verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("covariance_kernel_eval_core verification failed");
    $finish;
  end

endmodule
